// ----- src/salsa_pkg.sv -----
// Shared types, constants and round functions for the Salsa20 stream unit.
package salsa_pkg;

    // Default number of rounds (two per double-round cell).
    localparam int unsigned ROUND_COUNT_DEF = 20;

    // Widths of the stream payloads.
    localparam int unsigned BLOCK_W = 512;
    localparam int unsigned VBYTES_W = 7;
    localparam int unsigned S_TDATA_W = 520;
    localparam int unsigned M_TDATA_W = 512;

    // Bytes in one block.
    localparam logic [VBYTES_W-1:0] BLOCK_BYTES = 7'd64;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_0 = 3'd0;
    localparam logic [2:0] REG_KEY_1 = 3'd1;
    localparam logic [2:0] REG_KEY_2 = 3'd2;
    localparam logic [2:0] REG_KEY_3 = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

    // The "expand 32-byte k" constant words.
    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    typedef logic [31:0] t_word;
    typedef logic [15:0][31:0] t_state;
    typedef logic [3:0][31:0] t_quad;

    // Side data that travels down the cell row beside the working state.
    typedef struct packed {
        logic [63:0]          ctr;
        logic [BLOCK_W-1:0]   data;
        logic [VBYTES_W-1:0]  vbytes;
    } t_side;

    function automatic t_word rotl(input t_word v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // One quarter round; the four words come back in the order a, b, c, d.
    function automatic t_quad quarter(input t_word a, input t_word b,
                                      input t_word c, input t_word d);
        t_word nb;
        t_word nc;
        t_word nd;
        t_word na;
        nb = b ^ rotl(a + d, 7);
        nc = c ^ rotl(nb + a, 9);
        nd = d ^ rotl(nc + nb, 13);
        na = a ^ rotl(nd + nc, 18);
        return {nd, nc, nb, na};
    endfunction

    function automatic t_state apply_quarter(input t_state s, input int unsigned ia,
                                             input int unsigned ib, input int unsigned ic,
                                             input int unsigned id);
        t_state r;
        t_quad  q;
        r = s;
        q = quarter(s[ia], s[ib], s[ic], s[id]);
        r[ia] = q[0];
        r[ib] = q[1];
        r[ic] = q[2];
        r[id] = q[3];
        return r;
    endfunction

    // A column round followed by a row round.
    function automatic t_state double_round(input t_state s);
        t_state r;
        r = s;
        r = apply_quarter(r, 0, 4, 8, 12);
        r = apply_quarter(r, 5, 9, 13, 1);
        r = apply_quarter(r, 10, 14, 2, 6);
        r = apply_quarter(r, 15, 3, 7, 11);
        r = apply_quarter(r, 0, 1, 2, 3);
        r = apply_quarter(r, 5, 6, 7, 4);
        r = apply_quarter(r, 10, 11, 8, 9);
        r = apply_quarter(r, 15, 12, 13, 14);
        return r;
    endfunction

    // Builds the sixteen-word input state.
    function automatic t_state build_state(input logic [63:0] k0, input logic [63:0] k1,
                                           input logic [63:0] k2, input logic [63:0] k3,
                                           input logic [63:0] nonce,
                                           input logic [63:0] ctr);
        t_state s;
        s[0]  = SIGMA_0;
        s[1]  = k0[31:0];
        s[2]  = k0[63:32];
        s[3]  = k1[31:0];
        s[4]  = k1[63:32];
        s[5]  = SIGMA_1;
        s[6]  = nonce[31:0];
        s[7]  = nonce[63:32];
        s[8]  = ctr[31:0];
        s[9]  = ctr[63:32];
        s[10] = SIGMA_2;
        s[11] = k2[31:0];
        s[12] = k2[63:32];
        s[13] = k3[31:0];
        s[14] = k3[63:32];
        s[15] = SIGMA_3;
        return s;
    endfunction

endpackage

// ----- src/salsa_cell.sv -----
// One cell of the round chain: a registered Salsa20 double round plus side data.
module salsa_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  salsa_pkg::t_state i_state,
    input  salsa_pkg::t_side  i_side,
    output logic              o_valid,
    output salsa_pkg::t_state o_state,
    output salsa_pkg::t_side  o_side
);
    import salsa_pkg::*;

    logic   r_valid;
    t_state r_state;
    t_side  r_side;
    t_state n_state;

    // The round logic works on whatever the previous cell hands over.
    assign n_state = double_round(i_state);

    // Occupancy flag of this cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Working state and side data move on whenever the row advances.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_side  = r_side;

endmodule

// ----- src/salsa20_block_cipher_stream.sv -----
// Salsa20 counter-mode stream unit: configuration registers, cell row and output stage.
// Each beat on the slave stream is one 64-byte block with a count of valid leading bytes;
// the unit XORs it with the Salsa20 keystream for the current 64-bit block counter and
// zeroes every byte at or past the count (a count above 64 counts as 64). The keystream
// comes from a row of ROUND_COUNT/2 double-round cells, one per clock, so a new block is
// accepted every cycle unless the row stalls on a blocked output, and the sustained rate
// is one block per clock; a block enters the first cell on the accepting edge, passes
// through the cells in order and then the output register. The counter starts at zero
// after reset, is cleared by every nonce write and advances by one per accepted block.
// Keys and nonce are programmed over the APB port (64-bit registers at byte addresses 0,
// 8, 16, 24 and 32); the user must write them only while no block is in flight (not enforced).
module salsa20_block_cipher_stream #(
    parameter int unsigned ROUND_COUNT = salsa_pkg::ROUND_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [5:0]                       paddr,
    input  logic [63:0]                      pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready,
    // Slave stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: data_0 .. data_7 (64 bits each), valid_bytes (7 bits), one zero pad bit
    input  logic [salsa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // Master stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: out_0 .. out_7 (64 bits each)
    output logic [salsa_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import salsa_pkg::*;

    localparam int unsigned NUM_CELLS = ROUND_COUNT / 2;

    logic [63:0] r_key0;
    logic [63:0] r_key1;
    logic [63:0] r_key2;
    logic [63:0] r_key3;
    logic [63:0] r_nonce;
    logic [63:0] r_counter;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        adv;
    logic        in_beat;
    logic        out_load;

    logic        w_valid [NUM_CELLS+1];
    t_state      w_state [NUM_CELLS+1];
    t_side       w_side  [NUM_CELLS+1];

    t_state      init_state;
    t_state      ks;
    logic [VBYTES_W-1:0] vlim;
    logic [BLOCK_W-1:0]  byte_mask;
    logic [BLOCK_W-1:0]  n_out;

    logic                r_out_valid;
    logic [BLOCK_W-1:0]  r_out_data;

    // Configuration decode.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0  <= '0;
            r_key1  <= '0;
            r_key2  <= '0;
            r_key3  <= '0;
            r_nonce <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KEY_0: r_key0  <= pwdata;
                REG_KEY_1: r_key1  <= pwdata;
                REG_KEY_2: r_key2  <= pwdata;
                REG_KEY_3: r_key3  <= pwdata;
                REG_NONCE: r_nonce <= pwdata;
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (cfg_idx)
            REG_KEY_0: prdata = r_key0;
            REG_KEY_1: prdata = r_key1;
            REG_KEY_2: prdata = r_key2;
            REG_KEY_3: prdata = r_key3;
            REG_NONCE: prdata = r_nonce;
            default:   prdata = '0;
        endcase
    end

    // The row stalls only when its last cell is full and the output stage cannot drain.
    assign out_load      = !r_out_valid || m_axis_tready;
    assign adv           = !(w_valid[NUM_CELLS] && r_out_valid && !m_axis_tready);
    assign s_axis_tready = adv;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Block counter: cleared by a nonce write, otherwise advanced per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else if (cfg_wr && (cfg_idx == REG_NONCE)) begin
            r_counter <= '0;
        end else if (in_beat) begin
            r_counter <= r_counter + 64'd1;
        end
    end

    // Entry into the cell row.
    assign w_valid[0]         = s_axis_tvalid;
    assign w_state[0]         = build_state(r_key0, r_key1, r_key2, r_key3, r_nonce, r_counter);
    assign w_side[0].ctr      = r_counter;
    assign w_side[0].data     = s_axis_tdata[BLOCK_W-1:0];
    assign w_side[0].vbytes   = s_axis_tdata[BLOCK_W +: VBYTES_W];

    // Row of double-round cells.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        salsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (w_valid[g]),
            .i_state (w_state[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_state (w_state[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // Feed-forward add: the user must keep key and nonce stable in flight (not enforced).
    assign init_state = build_state(r_key0, r_key1, r_key2, r_key3, r_nonce,
                                    w_side[NUM_CELLS].ctr);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            ks[i] = w_state[NUM_CELLS][i] + init_state[i];
        end
    end

    // Byte mask from the valid count, clamped to a whole block.
    assign vlim = (w_side[NUM_CELLS].vbytes > BLOCK_BYTES) ? BLOCK_BYTES
                                                          : w_side[NUM_CELLS].vbytes;

    always_comb begin
        for (int b = 0; b < 64; b++) begin
            byte_mask[8*b +: 8] = (VBYTES_W'(b) < vlim) ? 8'hff : 8'h00;
        end
    end

    assign n_out = (w_side[NUM_CELLS].data ^ BLOCK_W'(ks)) & byte_mask;

    // Output register: it takes a new block only when it is empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= w_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && w_valid[NUM_CELLS]) begin
            r_out_data <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A full row facing a blocked output must not take a new beat.
    a_stall_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[NUM_CELLS] && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while the cell row is blocked");

    // Each accepted beat without a nonce write advances the counter by one.
    a_counter_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !(cfg_wr && (cfg_idx == REG_NONCE))) |=>
        (r_counter == $past(r_counter) + 64'd1))
        else $error("block counter did not advance on an accepted beat");

    // A nonce write restarts the counter.
    a_nonce_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && (cfg_idx == REG_NONCE)) |=> (r_counter == 64'd0))
        else $error("nonce write did not clear the block counter");

    // A result appears only when the last cell held a block.
    a_out_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_valid[NUM_CELLS]))
        else $error("output valid without a block in the last cell");

    // A waiting result is not replaced before it is taken.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending result changed before it was taken");

endmodule
